>>> src/rmfw_pkg.sv
// Package for the recursive lock with a FIFO wait queue.
// Holds the field widths, opcodes, status codes, controller states and the control/status structs.
// No dependencies.
package rmfw_pkg;

  localparam int unsigned THREAD_ID_BITS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH_DEF    = 16;
  localparam int unsigned COUNT_BITS_DEF     = 8;

  localparam int unsigned OP_W     = 1;
  localparam int unsigned TID_W    = 8;
  localparam int unsigned STATUS_W = 4;
  localparam int unsigned CNT_O_W  = 8;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 24;

  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACQUIRED    = 4'd0,
    ST_REENTERED   = 4'd1,
    ST_QUEUED      = 4'd2,
    ST_QFULL       = 4'd3,
    ST_DECREMENTED = 4'd4,
    ST_FREED       = 4'd5,
    ST_HANDOFF     = 4'd6,
    ST_NOT_HOLDER  = 4'd7,
    ST_SATURATED   = 4'd8
  } status_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } rmfw_cmd_t;

  typedef struct packed {
    logic out_blocked;
  } rmfw_stat_t;

endpackage

>>> src/rmfw_ctrl.sv
// Controller state machine of the recursive lock.
// Sequences capture and execution of one request; depends on rmfw_pkg.
module rmfw_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  rmfw_pkg::rmfw_stat_t stat,
  output rmfw_pkg::rmfw_cmd_t  cmd
);
  import rmfw_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CTL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      CTL_IDLE: begin
        if (in_tvalid) begin
          state_nxt = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        if (!stat.out_blocked) begin
          state_nxt = CTL_IDLE;
        end
      end
      default: state_nxt = CTL_IDLE;
    endcase
  end

  always_comb begin
    in_tready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      CTL_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      CTL_EXEC: begin
        cmd.exec = !stat.out_blocked;
      end
      default: ;
    endcase
  end

endmodule

>>> src/rmfw_dp.sv
// Datapath of the recursive lock: holder state, wait queue memory, result register.
// Driven by rmfw_ctrl commands; depends on rmfw_pkg.
module rmfw_dp #(
  parameter int unsigned THREAD_ID_BITS = rmfw_pkg::THREAD_ID_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH    = rmfw_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned COUNT_BITS     = rmfw_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [rmfw_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rmfw_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  rmfw_pkg::rmfw_cmd_t                 cmd,
  output rmfw_pkg::rmfw_stat_t                stat
);
  import rmfw_pkg::*;

  localparam int unsigned TB     = THREAD_ID_BITS;
  localparam int unsigned CB     = COUNT_BITS;
  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);
  localparam logic [CB-1:0]     CNT_MAX  = {CB{1'b1}};
  localparam logic [CB-1:0]     CNT_ONE  = CB'(1);

  logic [TB-1:0] wait_mem [QUEUE_DEPTH];

  logic              taken_r, taken_nxt;
  logic [TB-1:0]     owner_r, owner_nxt;
  logic [CB-1:0]     count_r, count_nxt;
  logic [PTR_W-1:0]  head_r, head_nxt;
  logic [PTR_W-1:0]  tail_r, tail_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;

  opcode_t       op_r;
  logic [TB-1:0] tid_r;
  logic [TB-1:0] head_data_r;

  logic          push;
  status_t       status;
  logic          woken_valid;
  logic [TB-1:0] woken;

  logic          out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [TB+TID_W-1:0] tid_ext;
  logic [TB+TID_W-1:0] woken_ext;
  logic [CB+CNT_O_W-1:0] count_ext;

  assign tid_ext = {{TB{1'b0}}, in_tdata[TID_W:OP_W]};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r        <= opcode_t'(in_tdata[0]);
      tid_r       <= tid_ext[TB-1:0];
      head_data_r <= wait_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push) begin
      wait_mem[tail_r] <= tid_r;
    end
  end

  always_comb begin
    taken_nxt   = taken_r;
    owner_nxt   = owner_r;
    count_nxt   = count_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    push        = 1'b0;
    woken_valid = 1'b0;
    woken       = '0;
    status      = ST_NOT_HOLDER;
    if (op_r == OP_ACQUIRE) begin
      priority if (!taken_r) begin
        taken_nxt = 1'b1;
        owner_nxt = tid_r;
        count_nxt = CNT_ONE;
        status    = ST_ACQUIRED;
      end else if (owner_r == tid_r) begin
        if (count_r == CNT_MAX) begin
          status = ST_SATURATED;
        end else begin
          count_nxt = count_r + CNT_ONE;
          status    = ST_REENTERED;
        end
      end else if (fill_r != FILL_MAX) begin
        push     = 1'b1;
        tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
        fill_nxt = fill_r + FILL_W'(1);
        status   = ST_QUEUED;
      end else begin
        status = ST_QFULL;
      end
    end else begin
      priority if (!taken_r || owner_r != tid_r) begin
        status = ST_NOT_HOLDER;
      end else if (count_r > CNT_ONE) begin
        count_nxt = count_r - CNT_ONE;
        status    = ST_DECREMENTED;
      end else if (fill_r != '0) begin
        woken       = head_data_r;
        woken_valid = 1'b1;
        head_nxt    = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
        fill_nxt    = fill_r - FILL_W'(1);
        owner_nxt   = head_data_r;
        count_nxt   = CNT_ONE;
        status      = ST_HANDOFF;
      end else begin
        taken_nxt = 1'b0;
        owner_nxt = '0;
        count_nxt = '0;
        status    = ST_FREED;
      end
    end
  end

  assign woken_ext = {{TID_W{1'b0}}, woken};
  assign count_ext = {{CNT_O_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= 1'b0;
      owner_r <= '0;
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
    end else if (cmd.exec) begin
      taken_r <= taken_nxt;
      owner_r <= owner_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_data_r <= {3'b000, count_ext[CNT_O_W-1:0], woken_ext[TID_W-1:0],
                     woken_valid, status};
    end
  end

  assign stat.out_blocked = out_valid_r && !out_tready;
  assign out_tvalid       = out_valid_r;
  assign out_tdata        = out_data_r;

endmodule

>>> src/recursive_mutex_fifo_waiters_top.sv
// Top level of the recursive lock with a FIFO wait queue.
// Instantiates rmfw_ctrl and rmfw_dp; depends on rmfw_pkg.
//
// Each request is an acquire or a release by a thread. The block handles one
// request at a time, in a capture step that takes it and reads the oldest
// waiter from the wait queue memory, then a decision step that updates the
// holder, count and queue and loads the result register. No new request is
// taken until the decision is done. A result waiting to be taken does not stop
// the next request from being captured, but the decision step holds until the
// result register is free. The queue memory needs no clearing after reset.
module recursive_mutex_fifo_waiters_top #(
  parameter int unsigned THREAD_ID_BITS = rmfw_pkg::THREAD_ID_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH    = rmfw_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned COUNT_BITS     = rmfw_pkg::COUNT_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: opcode[0], thread_id[8:1], zero padding[15:9].
  input  logic [rmfw_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: status[3:0], woken_valid[4], woken_thread[12:5],
  // hold_count[20:13], zero padding[23:21].
  output logic [rmfw_pkg::OUT_DATA_W-1:0] out_tdata
);
  import rmfw_pkg::*;

  rmfw_cmd_t  cmd;
  rmfw_stat_t stat;

  rmfw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rmfw_dp #(
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .QUEUE_DEPTH    (QUEUE_DEPTH),
    .COUNT_BITS     (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

>>> bench/lock_reply_checker.sv
`timescale 1ns / 100ps
// Checker for the recursive lock with a FIFO wait queue: watches both streams,
// predicts each reply from its own copy of the lock state and compares it.
// Depends on rmfw_pkg.
module lock_reply_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [rmfw_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [rmfw_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending
);
  import rmfw_pkg::*;

  localparam int unsigned          MAX_WAITERS   = QUEUE_DEPTH_DEF;
  localparam logic [CNT_O_W-1:0]   COUNT_CEILING = '1;
  localparam logic [CNT_O_W-1:0]   COUNT_ONE     = CNT_O_W'(1);

  typedef struct packed {
    status_t            status;
    logic               woken_valid;
    logic [TID_W-1:0]   woken_thread;
    logic [CNT_O_W-1:0] hold_count;
  } lock_reply_t;

  logic               lock_held;
  logic [TID_W-1:0]   holder_id;
  logic [CNT_O_W-1:0] hold_depth;
  logic [TID_W-1:0]   waiters[$];
  lock_reply_t        replies_due[$];
  int                 errors = 0;

  function automatic lock_reply_t resolve_request(opcode_t op, logic [TID_W-1:0] tid);
    lock_reply_t r;
    r.woken_valid = 1'b0;
    r.woken_thread = '0;
    if (op == OP_ACQUIRE) begin
      if (!lock_held) begin
        lock_held = 1'b1;
        holder_id = tid;
        hold_depth = COUNT_ONE;
        r.status = ST_ACQUIRED;
      end else if (holder_id == tid) begin
        if (hold_depth == COUNT_CEILING) begin
          r.status = ST_SATURATED;
        end else begin
          hold_depth++;
          r.status = ST_REENTERED;
        end
      end else if (waiters.size() < MAX_WAITERS) begin
        waiters.push_back(tid);
        r.status = ST_QUEUED;
      end else begin
        r.status = ST_QFULL;
      end
    end else begin
      if (!lock_held || holder_id != tid) begin
        r.status = ST_NOT_HOLDER;
      end else if (hold_depth > COUNT_ONE) begin
        hold_depth--;
        r.status = ST_DECREMENTED;
      end else if (waiters.size() != 0) begin
        // The oldest waiter takes the lock over directly with a count of one.
        holder_id = waiters.pop_front();
        hold_depth = COUNT_ONE;
        r.woken_valid = 1'b1;
        r.woken_thread = holder_id;
        r.status = ST_HANDOFF;
      end else begin
        lock_held = 1'b0;
        holder_id = '0;
        hold_depth = '0;
        r.status = ST_FREED;
      end
    end
    r.hold_count = hold_depth;
    return r;
  endfunction

  task automatic note_failure(string msg);
    errors++;
    if (errors <= 10) begin
      $display("%s", msg);
    end
  endtask

  task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      note_failure($sformatf("mismatch on %s: expected %0d, actual %0d", name, want, got));
    end
  endtask

  always @(posedge clk) begin
    lock_reply_t due;
    if (!rst_n) begin
      lock_held = 1'b0;
      holder_id = '0;
      hold_depth = '0;
      waiters.delete();
      replies_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (replies_due.size() == 0) begin
          note_failure($sformatf("reply 0x%06h arrived with no request outstanding", out_tdata));
        end else begin
          due = replies_due.pop_front();
          compare_field("status", 8'(due.status), 8'(out_tdata[3:0]));
          compare_field("woken_valid", 8'(due.woken_valid), 8'(out_tdata[4]));
          compare_field("woken_thread", due.woken_thread, out_tdata[12:5]);
          compare_field("hold_count", due.hold_count, out_tdata[20:13]);
          compare_field("padding", 8'd0, 8'(out_tdata[23:21]));
        end
      end
      if (in_tvalid && in_tready) begin
        replies_due.push_back(resolve_request(opcode_t'(in_tdata[0]), in_tdata[8:1]));
      end
    end
    fail_count <= errors;
    pending <= replies_due.size();
  end

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Top of the testbench for the recursive lock with a FIFO wait queue: makes
// the request stream and the reply back-pressure, and gives the verdict.
// Depends on rmfw_pkg, recursive_mutex_fifo_waiters_top and lock_reply_checker.
module tb;
  import rmfw_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 500_000;
  localparam int unsigned RANDOM_PER_PHASE = 60;
  localparam int unsigned POOL_SIZE        = 8;
  localparam int unsigned PHASES           = 4;
  localparam logic [TID_W-1:0] ID_LOW  = '0;
  localparam logic [TID_W-1:0] ID_HIGH = '1;
  localparam logic [TID_W-1:0] ID_MID  = 8'h5A;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          fail_count;
  int          pending;
  int unsigned cycles = 0;
  int          idle_by_phase[PHASES]  = '{0, 85, 0, 19};
  int          stall_by_phase[PHASES] = '{0, 0, 85, 19};
  logic [TID_W-1:0] pool[POOL_SIZE];

  always #5 clk = ~clk;

  recursive_mutex_fifo_waiters_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  lock_reply_checker checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99, 0) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_request(opcode_t op, logic [TID_W-1:0] tid);
    while ($urandom_range(99, 0) < sender_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {{(IN_DATA_W - OP_W - TID_W){1'b0}}, tid, op};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic run_directed();
    send_request(OP_RELEASE, ID_LOW);
    send_request(OP_ACQUIRE, ID_LOW);
    send_request(OP_ACQUIRE, ID_LOW);
    send_request(OP_RELEASE, ID_HIGH);
    send_request(OP_ACQUIRE, ID_HIGH);
    send_request(OP_ACQUIRE, ID_MID);
    send_request(OP_ACQUIRE, ID_HIGH);
    send_request(OP_RELEASE, ID_LOW);
    send_request(OP_RELEASE, ID_LOW);
    send_request(OP_RELEASE, ID_HIGH);
    send_request(OP_RELEASE, ID_MID);
    send_request(OP_RELEASE, ID_HIGH);
    // Fill the wait queue, overflow it, then hand the lock down the line.
    send_request(OP_ACQUIRE, ID_HIGH);
    for (int i = 1; i <= QUEUE_DEPTH_DEF + 1; i++) begin
      send_request(OP_ACQUIRE, TID_W'(i));
    end
    send_request(OP_RELEASE, ID_HIGH);
    for (int i = 1; i <= QUEUE_DEPTH_DEF; i++) begin
      send_request(OP_RELEASE, TID_W'(i));
    end
    // Climb the recursion count past its ceiling and unwind it again.
    send_request(OP_ACQUIRE, ID_MID);
    repeat (256) send_request(OP_ACQUIRE, ID_MID);
    repeat (255) send_request(OP_RELEASE, ID_MID);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned sent;
    int unsigned span;
    int unsigned active;
    int unsigned acq_pct;
    int unsigned roll;
    logic [TID_W-1:0] tid;
    opcode_t op;
    sent = 0;
    while (sent < count) begin
      span = $urandom_range(60, 10);
      active = $urandom_range(POOL_SIZE, 1);
      acq_pct = $urandom_range(70, 20);
      for (int unsigned i = 0; i < span && sent < count; i++) begin
        roll = $urandom_range(99, 0);
        op = ($urandom_range(99, 0) < acq_pct) ? OP_ACQUIRE : OP_RELEASE;
        if (roll < 5) begin
          // Stray releases from arbitrary threads; acquires stay within the
          // pool so the lock always comes back to a thread that releases.
          op = OP_RELEASE;
          tid = TID_W'($urandom());
        end else if (roll < 20) begin
          tid = pool[$urandom_range(POOL_SIZE - 1, 0)];
        end else begin
          tid = pool[$urandom_range(active - 1, 0)];
        end
        send_request(op, tid);
        sent++;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = TID_W'($urandom());
    end
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    run_directed();
    for (int p = 0; p < PHASES; p++) begin
      sender_idle_pct = idle_by_phase[p];
      receiver_stall_pct = stall_by_phase[p];
      run_random(RANDOM_PER_PHASE);
    end
    in_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
src/rmfw_pkg.sv
src/rmfw_ctrl.sv
src/rmfw_dp.sv
src/recursive_mutex_fifo_waiters_top.sv
bench/lock_reply_checker.sv
bench/tb.sv
